// ----- hw/rtl/fls_pkg.sv -----
// shared types and constants for the letter frequency sort block
// no dependencies
package fls_pkg;

   localparam int DEF_ALPHABET_SIZE = 26;
   localparam int DEF_COUNT_BITS    = 16;

   localparam int CHAR_W  = 8;
   localparam int INDEX_W = 5;
   localparam int COUNT_W = 16;

   localparam logic [CHAR_W-1:0] LETTER_BASE = 8'd97;

   typedef struct packed {
      logic [CHAR_W-1:0] char_code;
      logic              last_char;
   } req_type;

   typedef struct packed {
      logic [INDEX_W-1:0] letter_index;
      logic [COUNT_W-1:0] letter_count;
      logic               last_entry;
   } rsp_type;

   // strobes from the sequencer to the counter memory
   typedef struct packed {
      logic rd_en;
      logic wr_en;
      logic clr_all;
   } mem_ctl_type;

endpackage

// ----- hw/rtl/fls_mem.sv -----
// letter counter memory with per-entry valid bits and registered read
// depends on fls_pkg
module fls_mem import fls_pkg::*; #(
   parameter int ALPHABET_SIZE = DEF_ALPHABET_SIZE,
   parameter int COUNT_BITS    = DEF_COUNT_BITS,
   localparam int IW           = $clog2(ALPHABET_SIZE)
) (
   input  logic                  clock,
   input  logic                  reset,
   input  mem_ctl_type           mem_ctl,
   input  logic [IW-1:0]         mem_addr,
   input  logic [COUNT_BITS-1:0] mem_wdata,
   output logic [COUNT_BITS-1:0] mem_rdata
);

   logic [COUNT_BITS-1:0]    mem_ff [ALPHABET_SIZE];
   logic [ALPHABET_SIZE-1:0] valid_ff;
   logic [COUNT_BITS-1:0]    rdata_ff;

   // an entry that is not valid reads as zero, so clearing only resets the valid bits
   always_ff @(posedge clock) begin
      if (reset) begin
         valid_ff <= '0;
      end else if (mem_ctl.clr_all) begin
         valid_ff <= '0;
      end else if (mem_ctl.wr_en) begin
         valid_ff[mem_addr] <= 1'b1;
      end
   end

   always_ff @(posedge clock) begin
      if (mem_ctl.wr_en) begin
         mem_ff[mem_addr] <= mem_wdata;
      end
      if (mem_ctl.rd_en) begin
         rdata_ff <= valid_ff[mem_addr] ? mem_ff[mem_addr] : '0;
      end
   end

   assign mem_rdata = rdata_ff;

endmodule

// ----- hw/rtl/fls_ctrl.sv -----
// sequencer: counts letters, then repeatedly scans for the largest count
// with one shared compare unit and emits the entries; depends on fls_pkg
module fls_ctrl import fls_pkg::*; #(
   parameter int ALPHABET_SIZE = DEF_ALPHABET_SIZE,
   parameter int COUNT_BITS    = DEF_COUNT_BITS,
   localparam int IW           = $clog2(ALPHABET_SIZE)
) (
   input  logic                  clock,
   input  logic                  reset,
   input  logic                  req_valid,
   output logic                  req_ready,
   input  req_type               req_data,
   output logic                  rsp_valid,
   input  logic                  rsp_ready,
   output rsp_type               rsp_data,
   output mem_ctl_type           mem_ctl,
   output logic [IW-1:0]         mem_addr,
   output logic [COUNT_BITS-1:0] mem_wdata,
   input  logic [COUNT_BITS-1:0] mem_rdata
);

   typedef enum logic [7:0] {
      ST_IDLE     = 8'b0000_0001,
      ST_RD       = 8'b0000_0010,
      ST_INC      = 8'b0000_0100,
      ST_SCAN_RD  = 8'b0000_1000,
      ST_SCAN_CMP = 8'b0001_0000,
      ST_DECIDE   = 8'b0010_0000,
      ST_PUT      = 8'b0100_0000,
      ST_LAST     = 8'b1000_0000
   } state_type;

   localparam logic [IW-1:0]         LAST_IDX  = IW'(ALPHABET_SIZE - 1);
   localparam logic [COUNT_BITS-1:0] COUNT_MAX = '1;

   state_type             state_ff, state_in;
   logic [IW-1:0]         letter_idx_ff, letter_idx_in;
   logic                  last_ff, last_in;
   logic [IW-1:0]         scan_idx_ff, scan_idx_in;
   logic [IW-1:0]         best_idx_ff, best_idx_in;
   logic [COUNT_BITS-1:0] best_cnt_ff, best_cnt_in;
   logic                  pend_vld_ff, pend_vld_in;
   logic [IW-1:0]         pend_idx_ff, pend_idx_in;
   logic [COUNT_BITS-1:0] pend_cnt_ff, pend_cnt_in;
   logic                  rsp_valid_ff, rsp_valid_in;
   rsp_type               rsp_data_ff, rsp_data_in;

   logic [CHAR_W-1:0] letter_off;
   logic              is_letter;
   logic              req_take;
   logic              out_free;
   logic              best_nz;

   assign letter_off = req_data.char_code - LETTER_BASE;
   assign is_letter  = (req_data.char_code >= LETTER_BASE) &&
                       (letter_off < CHAR_W'(ALPHABET_SIZE));
   assign req_take   = req_valid && state_ff == ST_IDLE;
   assign out_free   = !rsp_valid_ff || rsp_ready;
   assign best_nz    = best_cnt_ff != '0;

   always_comb begin
      state_in      = state_ff;
      letter_idx_in = letter_idx_ff;
      last_in       = last_ff;
      scan_idx_in   = scan_idx_ff;
      best_idx_in   = best_idx_ff;
      best_cnt_in   = best_cnt_ff;
      pend_vld_in   = pend_vld_ff;
      pend_idx_in   = pend_idx_ff;
      pend_cnt_in   = pend_cnt_ff;
      rsp_valid_in  = rsp_valid_ff && !rsp_ready;
      rsp_data_in   = rsp_data_ff;
      mem_ctl       = '0;
      mem_addr      = letter_idx_ff;
      mem_wdata     = '0;

      unique case (state_ff)
         ST_IDLE: begin
            if (req_take) begin
               letter_idx_in = letter_off[IW-1:0];
               last_in       = req_data.last_char;
               scan_idx_in   = '0;
               best_idx_in   = '0;
               best_cnt_in   = '0;
               if (is_letter) begin
                  state_in = ST_RD;
               end else if (req_data.last_char) begin
                  state_in = ST_SCAN_RD;
               end
            end
         end
         ST_RD: begin
            mem_ctl.rd_en = 1'b1;
            state_in      = ST_INC;
         end
         ST_INC: begin
            // saturating increment
            mem_ctl.wr_en = 1'b1;
            mem_wdata     = (mem_rdata == COUNT_MAX) ? mem_rdata
                                                     : mem_rdata + COUNT_BITS'(1);
            state_in      = last_ff ? ST_SCAN_RD : ST_IDLE;
         end
         ST_SCAN_RD: begin
            mem_ctl.rd_en = 1'b1;
            mem_addr      = scan_idx_ff;
            state_in      = ST_SCAN_CMP;
         end
         ST_SCAN_CMP: begin
            // strict compare keeps the lowest index on ties
            if (mem_rdata > best_cnt_ff) begin
               best_cnt_in = mem_rdata;
               best_idx_in = scan_idx_ff;
            end
            if (scan_idx_ff == LAST_IDX) begin
               state_in = ST_DECIDE;
            end else begin
               scan_idx_in = scan_idx_ff + IW'(1);
               state_in    = ST_SCAN_RD;
            end
         end
         ST_DECIDE: begin
            if (best_nz) begin
               // remove the winner so the next pass finds the runner-up
               mem_ctl.wr_en = 1'b1;
               mem_addr      = best_idx_ff;
               if (pend_vld_ff) begin
                  state_in = ST_PUT;
               end else begin
                  pend_vld_in = 1'b1;
                  pend_idx_in = best_idx_ff;
                  pend_cnt_in = best_cnt_ff;
                  scan_idx_in = '0;
                  best_idx_in = '0;
                  best_cnt_in = '0;
                  state_in    = ST_SCAN_RD;
               end
            end else begin
               state_in = ST_LAST;
            end
         end
         ST_PUT: begin
            if (out_free) begin
               rsp_valid_in              = 1'b1;
               rsp_data_in.letter_index  = INDEX_W'(pend_idx_ff);
               rsp_data_in.letter_count  = COUNT_W'(pend_cnt_ff);
               rsp_data_in.last_entry    = 1'b0;
               pend_idx_in               = best_idx_ff;
               pend_cnt_in               = best_cnt_ff;
               scan_idx_in               = '0;
               best_idx_in               = '0;
               best_cnt_in               = '0;
               state_in                  = ST_SCAN_RD;
            end
         end
         ST_LAST: begin
            if (out_free) begin
               rsp_valid_in = 1'b1;
               if (pend_vld_ff) begin
                  rsp_data_in.letter_index = INDEX_W'(pend_idx_ff);
                  rsp_data_in.letter_count = COUNT_W'(pend_cnt_ff);
               end else begin
                  rsp_data_in.letter_index = '0;
                  rsp_data_in.letter_count = '0;
               end
               rsp_data_in.last_entry = 1'b1;
               pend_vld_in            = 1'b0;
               mem_ctl.clr_all        = 1'b1;
               state_in               = ST_IDLE;
            end
         end
         default: begin
            state_in = ST_IDLE;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= ST_IDLE;
         pend_vld_ff  <= 1'b0;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         pend_vld_ff  <= pend_vld_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      letter_idx_ff <= letter_idx_in;
      last_ff       <= last_in;
      scan_idx_ff   <= scan_idx_in;
      best_idx_ff   <= best_idx_in;
      best_cnt_ff   <= best_cnt_in;
      pend_idx_ff   <= pend_idx_in;
      pend_cnt_ff   <= pend_cnt_in;
      rsp_data_ff   <= rsp_data_in;
   end

   assign req_ready = state_ff == ST_IDLE;
   assign rsp_valid = rsp_valid_ff;
   assign rsp_data  = rsp_data_ff;

endmodule

// ----- hw/rtl/letter_frequency_sort_top.sv -----
// letter frequency sort: a non-letter that is not last is taken while idle, a letter is
// read, then saturating written back to the counter memory; a new transaction is taken
// only after the last one is done. on the last transaction the block runs k+1 scan passes
// for k nonzero letters, each pass reading every counter in turn, and emits the entries,
// each entry also waiting for rsp_ready; the single memory port and shared compare unit make the scan serial.
// reset clears the sequencer, output valid and the counter valid bits
module letter_frequency_sort_top import fls_pkg::*; #(
   parameter int ALPHABET_SIZE = DEF_ALPHABET_SIZE,
   parameter int COUNT_BITS    = DEF_COUNT_BITS
) (
   input  logic    clock,
   input  logic    reset,
   input  logic    req_valid,
   output logic    req_ready,
   input  req_type req_data,
   output logic    rsp_valid,
   input  logic    rsp_ready,
   output rsp_type rsp_data
);

   localparam int IW = $clog2(ALPHABET_SIZE);

   mem_ctl_type           mem_ctl;
   logic [IW-1:0]         mem_addr;
   logic [COUNT_BITS-1:0] mem_wdata;
   logic [COUNT_BITS-1:0] mem_rdata;

   fls_ctrl #(
      .ALPHABET_SIZE (ALPHABET_SIZE),
      .COUNT_BITS    (COUNT_BITS)
   ) u_ctrl (
      .clock     (clock),
      .reset     (reset),
      .req_valid (req_valid),
      .req_ready (req_ready),
      .req_data  (req_data),
      .rsp_valid (rsp_valid),
      .rsp_ready (rsp_ready),
      .rsp_data  (rsp_data),
      .mem_ctl   (mem_ctl),
      .mem_addr  (mem_addr),
      .mem_wdata (mem_wdata),
      .mem_rdata (mem_rdata)
   );

   fls_mem #(
      .ALPHABET_SIZE (ALPHABET_SIZE),
      .COUNT_BITS    (COUNT_BITS)
   ) u_mem (
      .clock     (clock),
      .reset     (reset),
      .mem_ctl   (mem_ctl),
      .mem_addr  (mem_addr),
      .mem_wdata (mem_wdata),
      .mem_rdata (mem_rdata)
   );

endmodule

// ----- hw/rtl/fls_check.sv -----
// port-level checks for letter_frequency_sort_top, attached by bind
// depends on fls_pkg
module fls_check import fls_pkg::*; #(
   parameter int ALPHABET_SIZE = DEF_ALPHABET_SIZE
) (
   input logic    clock,
   input logic    reset,
   input logic    req_valid,
   input logic    req_ready,
   input req_type req_data,
   input logic    rsp_valid,
   input logic    rsp_ready,
   input rsp_type rsp_data
);

   localparam logic [INDEX_W-1:0] MAX_IDX = INDEX_W'(ALPHABET_SIZE - 1);

   // a stalled result transaction holds
   a_rsp_hold: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && !rsp_ready |=> rsp_valid && $stable(rsp_data))
      else $error("result changed while stalled");

   // the last character starts the sort, so input must stall
   a_last_stalls: assert property (@(posedge clock) disable iff (reset)
      req_valid && req_ready && req_data.last_char |=> !req_ready)
      else $error("input ready right after last character");

   // results are only produced while the sort sequencer runs
   a_rsp_from_sort: assert property (@(posedge clock) disable iff (reset)
      $rose(rsp_valid) |-> $past(!req_ready))
      else $error("result appeared while idle");

   a_index_range: assert property (@(posedge clock) disable iff (reset)
      rsp_valid |-> rsp_data.letter_index <= MAX_IDX)
      else $error("letter index out of range");

endmodule

bind letter_frequency_sort_top fls_check #(
   .ALPHABET_SIZE (ALPHABET_SIZE)
) u_fls_check (.*);

// ----- dv/tb_letter_frequency_sort_top.sv -----
// testbench for letter_frequency_sort_top: random character streams against a local letter
// histogram predictor, with sorted results checked in order on the response channel
// depends on fls_pkg and letter_frequency_sort_top
`timescale 1ns / 1ps

module tb_letter_frequency_sort_top;
   import fls_pkg::*;

   localparam int ALPHA       = DEF_ALPHABET_SIZE;
   localparam int TALLY_W     = DEF_COUNT_BITS;
   localparam int CYCLE_LIMIT = 1200000;
   localparam int RANDOM_CHARS = 170;

   localparam logic [TALLY_W-1:0] TALLY_MAX = '1;

   typedef enum int {MIX_ALPHABET, MIX_FEW_LETTERS, MIX_ANY_BYTE, MIX_NO_LETTERS} text_mix_type;

   typedef struct {
      req_type     payload;
      int unsigned gap_after;
      bit          drain;
   } text_item_type;

   logic    clock;
   logic    reset     = 1'b1;
   logic    req_valid = 1'b0;
   logic    req_ready;
   req_type req_data  = '0;
   logic    rsp_valid;
   logic    rsp_ready = 1'b0;
   rsp_type rsp_data;

   text_item_type      text_backlog [$];
   rsp_type            ranked_due [$];
   logic [TALLY_W-1:0] letter_tally [ALPHA];
   int unsigned        chars_queued   = 0;
   int unsigned        chars_accepted = 0;
   int unsigned        errors         = 0;
   int unsigned        cycle_count    = 0;

   letter_frequency_sort_top dut (
      .clock     (clock),
      .reset     (reset),
      .req_valid (req_valid),
      .req_ready (req_ready),
      .req_data  (req_data),
      .rsp_valid (rsp_valid),
      .rsp_ready (rsp_ready),
      .rsp_data  (rsp_data)
   );

   initial begin
      clock = 1'b0;
      forever #4 clock = ~clock;
   end

   // mostly short pauses, now and then a long one
   function automatic int unsigned pick_gap();
      int unsigned r;
      r = $urandom_range(0, 15);
      if (r < 8)
         return 1;
      else if (r < 14)
         return $urandom_range(2, 4);
      else
         return $urandom_range(20, 60);
   endfunction

   function automatic void queue_char(input logic [7:0] code, input bit last, input bit calm,
                                      input bit drain);
      text_item_type item;
      item.payload.char_code = code;
      item.payload.last_char = last;
      item.gap_after = (calm || $urandom_range(0, 2) != 0) ? 0 : pick_gap();
      item.drain = drain;
      text_backlog.push_back(item);
      chars_queued++;
   endfunction

   // count one character; on the last one rank letters by count, ties alphabetical
   function automatic void tally_char(input req_type t);
      int unsigned     code;
      int              best;
      int              emitted;
      bit [ALPHA-1:0]  taken;
      rsp_type         entry;
      code = t.char_code;
      if (code >= LETTER_BASE && code - LETTER_BASE < ALPHA) begin
         if (letter_tally[code - LETTER_BASE] != TALLY_MAX)
            letter_tally[code - LETTER_BASE]++;
      end
      if (!t.last_char)
         return;
      taken = '0;
      emitted = 0;
      entry = '0;
      do begin
         best = -1;
         for (int l = 0; l < ALPHA; l++) begin
            if (!taken[l] && letter_tally[l] != 0 &&
                (best < 0 || letter_tally[l] > letter_tally[best]))
               best = l;
         end
         if (best >= 0) begin
            if (emitted > 0)
               ranked_due.push_back(entry);
            taken[best] = 1'b1;
            entry.letter_index = INDEX_W'(best);
            entry.letter_count = COUNT_W'(letter_tally[best]);
            entry.last_entry = 1'b0;
            emitted++;
         end
      end while (best >= 0);
      // with no letter seen this is the single zero entry
      entry.last_entry = 1'b1;
      ranked_due.push_back(entry);
      for (int l = 0; l < ALPHA; l++)
         letter_tally[l] = '0;
   endfunction

   // request driver, also feeds the predictor on every accepted transaction
   always @(posedge clock) begin : drive_req
      int unsigned   hold_off;
      logic          nxt_valid;
      req_type       nxt_data;
      text_item_type item;
      nxt_valid = req_valid;
      nxt_data = req_data;
      if (reset) begin
         nxt_valid = 1'b0;
         hold_off = 0;
         for (int l = 0; l < ALPHA; l++)
            letter_tally[l] = '0;
      end else begin
         if (req_valid && req_ready) begin
            tally_char(req_data);
            chars_accepted++;
            nxt_valid = 1'b0;
         end
         if (!nxt_valid) begin
            if (hold_off > 0)
               hold_off--;
            else if (text_backlog.size() > 0 &&
                     !(text_backlog[0].drain && ranked_due.size() > 0)) begin
               item = text_backlog.pop_front();
               nxt_data = item.payload;
               nxt_valid = 1'b1;
               hold_off = item.gap_after;
            end
         end
      end
      req_valid <= nxt_valid;
      req_data <= nxt_data;
   end

   // response monitor with random backpressure
   always @(posedge clock) begin : watch_rsp
      int unsigned stall_left;
      int unsigned calm_left;
      rsp_type     want;
      if (reset) begin
         rsp_ready <= 1'b0;
         stall_left = 0;
         calm_left = 0;
      end else begin
         if (rsp_valid && rsp_ready) begin
            if (ranked_due.size() == 0) begin
               $display("%0t unexpected transaction: index %0d count %0d last %0d", $time,
                        rsp_data.letter_index, rsp_data.letter_count, rsp_data.last_entry);
               errors++;
            end else begin
               want = ranked_due.pop_front();
               if (rsp_data.letter_index !== want.letter_index) begin
                  $display("%0t letter_index: expected %0d actual %0d", $time,
                           want.letter_index, rsp_data.letter_index);
                  errors++;
               end
               if (rsp_data.letter_count !== want.letter_count) begin
                  $display("%0t letter_count: expected %0d actual %0d", $time,
                           want.letter_count, rsp_data.letter_count);
                  errors++;
               end
               if (rsp_data.last_entry !== want.last_entry) begin
                  $display("%0t last_entry: expected %0d actual %0d", $time,
                           want.last_entry, rsp_data.last_entry);
                  errors++;
               end
            end
         end
         if (stall_left > 0) begin
            stall_left--;
            rsp_ready <= 1'b0;
         end else begin
            rsp_ready <= 1'b1;
            if (calm_left > 0)
               calm_left--;
            else if ($urandom_range(0, 3) == 0)
               stall_left = pick_gap();
            else if ($urandom_range(0, 40) == 0)
               calm_left = $urandom_range(100, 300);
         end
      end
   end

   always @(posedge clock) begin
      cycle_count++;
      if (cycle_count >= CYCLE_LIMIT) begin
         $display("TB_ERROR");
         $finish;
      end
   end

   initial begin : stimulus
      int unsigned  n_random;
      int unsigned  len;
      int unsigned  narrow_base;
      int unsigned  r;
      bit           calm;
      bit           drain;
      logic [7:0]   code;
      text_mix_type mix;

      // nothing counted: single zero entry, both with a low and a high byte
      queue_char(8'h00, 1'b1, 1'b0, 1'b0);
      queue_char(8'hFF, 1'b1, 1'b0, 1'b0);

      // alphabet edges, neighbors just outside it, a tie, ended on a non-letter
      queue_char("z", 1'b0, 1'b0, 1'b1);
      queue_char("a", 1'b0, 1'b0, 1'b0);
      queue_char(8'h60, 1'b0, 1'b0, 1'b0);   // one below a
      queue_char(8'h7B, 1'b0, 1'b0, 1'b0);   // one above z
      queue_char(8'h0A, 1'b0, 1'b0, 1'b0);
      queue_char("a", 1'b0, 1'b0, 1'b0);
      queue_char("z", 1'b0, 1'b0, 1'b0);
      queue_char("m", 1'b0, 1'b0, 1'b0);
      queue_char(8'hFF, 1'b1, 1'b0, 1'b0);

      // letter on the closing transaction is counted too
      queue_char("q", 1'b0, 1'b0, 1'b0);
      queue_char("b", 1'b0, 1'b0, 1'b0);
      queue_char("q", 1'b0, 1'b0, 1'b0);
      queue_char("b", 1'b1, 1'b0, 1'b0);

      // back to back burst after the pipe has drained
      queue_char("d", 1'b0, 1'b1, 1'b1);
      for (int k = 0; k < 12; k++)
         queue_char("c", 1'b0, 1'b1, 1'b0);
      queue_char("a", 1'b1, 1'b1, 1'b0);

      n_random = 0;
      while (n_random < RANDOM_CHARS) begin
         r = $urandom_range(0, 9);
         mix = (r < 4) ? MIX_ALPHABET : (r < 7) ? MIX_FEW_LETTERS :
               (r < 9) ? MIX_ANY_BYTE : MIX_NO_LETTERS;
         calm = ($urandom_range(0, 3) == 0);
         drain = ($urandom_range(0, 4) == 0);
         narrow_base = $urandom_range(0, ALPHA - 4);
         case (mix)
            MIX_ALPHABET:    len = $urandom_range(15, 45);
            MIX_FEW_LETTERS: len = $urandom_range(2, 12);
            MIX_ANY_BYTE:    len = $urandom_range(1, 20);
            default:         len = $urandom_range(1, 3);
         endcase
         for (int k = 0; k < len; k++) begin
            case (mix)
               MIX_ALPHABET: begin
                  if ($urandom_range(0, 7) == 0)
                     code = 8'($urandom_range(0, 255));
                  else
                     code = 8'(LETTER_BASE + $urandom_range(0, ALPHA - 1));
               end
               MIX_FEW_LETTERS: code = 8'(LETTER_BASE + narrow_base + $urandom_range(0, 3));
               MIX_ANY_BYTE:    code = 8'($urandom_range(0, 255));
               default: begin
                  r = $urandom_range(0, 255 - ALPHA);
                  code = 8'((r < LETTER_BASE) ? r : r + ALPHA);
               end
            endcase
            queue_char(code, k == len - 1, calm, drain && k == 0);
         end
         n_random += len;
      end

      repeat (9) @(posedge clock);
      reset <= 1'b0;

      while (chars_accepted < chars_queued || ranked_due.size() > 0)
         @(posedge clock);
      repeat (200) @(posedge clock);

      if (errors == 0)
         $display("TB_OK");
      else
         $display("TB_ERROR");
      $finish;
   end

endmodule
